@@ hdl/sitl_pkg.sv @@
package sitl_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ID_WIDTH    = 8;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // fixed field widths of the beats
  localparam int VAL_W       = 31;
  localparam int IN_ID_W     = 8;
  localparam int ENTRY_IDX_W = 10;
  localparam int ENTRY_CNT_W = 11;

  // opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [IN_ID_W-1:0] chrom_id;
    logic [VAL_W-1:0]   interval_start;
    logic [VAL_W-1:0]   interval_end;
    logic [VAL_W-1:0]   position;
    logic               ratio_flag;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   hit;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [1:0]             source_class;
    logic [ENTRY_CNT_W-1:0] entry_count;
  } out_beat_t;

  // one stored interval, ordered by (id, start, end) as a packed word
  typedef struct packed {
    logic [ID_WIDTH-1:0] id;
    logic [VAL_W-1:0]    ivl_start;
    logic [VAL_W-1:0]    ivl_end;
  } entry_t;

  // engine status toward the channel logic
  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

endpackage

@@ hdl/sorted_interval_table_lookup_core.sv @@
// Sorted interval table: holds half-open intervals ordered by (id, start, end)
// in a single-port-read, single-port-write memory and answers position lookups.
// Input channel in_valid/in_stall/in_data carries clear, insert and query beats;
// each beat gives exactly one result beat on out_valid/out_stall/out_data.
// One beat is worked on at a time; in_stall stays high from acceptance until
// its result moves into the output register, so a new beat can be taken while
// the previous result still waits there.
// Work per beat is set by the memory read loop of the search (each probe reads
// then compares, at most ceil(log2(n+1)) probes for n stored entries): clear,
// unused opcodes, rejected inserts and queries on an empty table or at position
// zero skip the search; a query reads the candidate entry after its search; an
// insert also shifts each entry at or above its slot up one place (n - slot)
// before the write. The result beat becomes valid in the same cycle in which
// the next input beat can be taken.
// Reset (rst_n low, synchronous) empties the table and drops any pending
// result; no clearing pass is run. While out_stall is high the output beat
// holds, and a finished result waits inside the engine until the register frees.
module sorted_interval_table_lookup_core import sitl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  eng_stat_t eng_stat;
  out_beat_t eng_res;
  logic      eng_start;
  logic      eng_take;
  logic      out_valid_r;
  out_beat_t out_data_r;

  // input beat goes straight to the engine when it is idle
  assign in_stall  = eng_stat.busy;
  assign eng_start = in_valid && !in_stall;

  sitl_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .start (eng_start),
    .cmd   (in_data),
    .take  (eng_take),
    .stat  (eng_stat),
    .res   (eng_res)
  );

  // output register
  assign eng_take = eng_stat.done && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_take) begin
      out_valid_r <= 1'b1;
      out_data_r  <= eng_res;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    eng_start |=> in_stall)
    else $error("engine not busy after accepting a beat");

  a_class_tracks_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.hit == out_data_r.source_class[1]))
    else $error("source class disagrees with hit");

  a_no_hit_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != STAT_OK)) |->
      (!out_data_r.hit && (out_data_r.source_class == 2'b00)))
    else $error("rejected insert reports a lookup result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.entry_count <= ENTRY_CNT_W'(TABLE_DEPTH)))
    else $error("entry count beyond table depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result lost or changed");

endmodule

@@ hdl/sitl_engine.sv @@
module sitl_engine import sitl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_beat_t  cmd,
  input  logic      take,
  output eng_stat_t stat,
  output out_beat_t res
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SH_RD,
    ST_SH_MV,
    ST_INS_WR,
    ST_Q_RD,
    ST_Q_CHK,
    ST_DONE
  } state_t;

  state_t                 state_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       lo_r;
  logic [CNT_W-1:0]       hi_r;
  logic [IDX_W-1:0]       mid_r;
  logic [IDX_W-1:0]       ptr_r;
  logic [ID_WIDTH-1:0]    id_r;
  logic [VAL_W-1:0]       key_start_r;
  logic [VAL_W-1:0]       key_end_r;
  logic                   is_ins_r;
  logic                   ratio_r;
  logic [1:0]             status_r;
  logic                   hit_r;
  logic [ENTRY_IDX_W-1:0] idx_r;
  logic [1:0]             class_r;

  // interval store
  entry_t           mem [TABLE_DEPTH];
  entry_t           rd_data_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  logic [CNT_W-1:0] mid_w;
  logic [IDX_W-1:0] lo_idx;
  logic             gt;
  logic [CNT_W-1:0] lo_step;
  logic [CNT_W-1:0] hi_step;
  logic             q_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // search midpoint and insertion slot
  assign mid_w  = lo_r + ((hi_r - lo_r) >> 1);
  assign lo_idx = lo_r[IDX_W-1:0];

  // probe compare: full key on insert, (id, start) against position on query
  always_comb begin
    if (is_ins_r) begin
      gt = rd_data_r > {id_r, key_start_r, key_end_r};
    end else begin
      gt = {rd_data_r.id, rd_data_r.ivl_start} > {id_r, key_start_r};
    end
    lo_step = gt ? lo_r : (CNT_W'(mid_r) + CNT_W'(1));
    hi_step = gt ? CNT_W'(mid_r) : hi_r;
  end

  // final containment test on the candidate entry
  assign q_hit = (rd_data_r.id == id_r) && (rd_data_r.ivl_start <= key_start_r) &&
                 (key_start_r < rd_data_r.ivl_end);

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data_r;
    unique case (state_r)
      ST_SRCH_RD: begin
        rd_en   = 1'b1;
        rd_addr = mid_w[IDX_W-1:0];
      end
      ST_SH_RD: begin
        rd_en   = 1'b1;
        rd_addr = IDX_W'(count_r - CNT_W'(1));
      end
      ST_SH_MV: begin
        // move entry up one slot while fetching the one below
        wr_en   = 1'b1;
        wr_addr = ptr_r + IDX_W'(1);
        if (ptr_r != lo_idx) begin
          rd_en   = 1'b1;
          rd_addr = ptr_r - IDX_W'(1);
        end
      end
      ST_INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = lo_idx;
        wr_data = {id_r, key_start_r, key_end_r};
      end
      ST_Q_RD: begin
        rd_en   = 1'b1;
        rd_addr = lo_idx - IDX_W'(1);
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            id_r      <= ID_WIDTH'(cmd.chrom_id);
            is_ins_r  <= (cmd.opcode == OP_INSERT);
            ratio_r   <= cmd.ratio_flag;
            key_end_r <= cmd.interval_end;
            if (cmd.opcode == OP_INSERT) begin
              key_start_r <= cmd.interval_start;
            end else begin
              key_start_r <= cmd.position - VAL_W'(1);
            end
            lo_r     <= '0;
            hi_r     <= count_r;
            status_r <= STAT_OK;
            hit_r    <= 1'b0;
            idx_r    <= '0;
            class_r  <= 2'b00;
            unique case (cmd.opcode)
              OP_CLEAR: begin
                count_r <= '0;
                state_r <= ST_DONE;
              end
              OP_INSERT: begin
                priority if (cmd.interval_start >= cmd.interval_end) begin
                  status_r <= STAT_INVALID;
                  state_r  <= ST_DONE;
                end else if (count_r == CNT_W'(TABLE_DEPTH)) begin
                  status_r <= STAT_FULL;
                  state_r  <= ST_DONE;
                end else if (count_r == '0) begin
                  state_r <= ST_INS_WR;
                end else begin
                  state_r <= ST_SRCH_RD;
                end
              end
              OP_QUERY: begin
                class_r <= {1'b0, cmd.ratio_flag};
                if ((cmd.position == '0) || (count_r == '0)) begin
                  state_r <= ST_DONE;
                end else begin
                  state_r <= ST_SRCH_RD;
                end
              end
              default: state_r <= ST_DONE;
            endcase
          end
        end
        ST_SRCH_RD: begin
          mid_r   <= mid_w[IDX_W-1:0];
          state_r <= ST_SRCH_CMP;
        end
        ST_SRCH_CMP: begin
          lo_r <= lo_step;
          hi_r <= hi_step;
          priority if (lo_step < hi_step) begin
            state_r <= ST_SRCH_RD;
          end else if (is_ins_r) begin
            state_r <= (lo_step == count_r) ? ST_INS_WR : ST_SH_RD;
          end else if (lo_step != '0) begin
            state_r <= ST_Q_RD;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_SH_RD: begin
          ptr_r   <= IDX_W'(count_r - CNT_W'(1));
          state_r <= ST_SH_MV;
        end
        ST_SH_MV: begin
          if (ptr_r == lo_idx) begin
            state_r <= ST_INS_WR;
          end else begin
            ptr_r <= ptr_r - IDX_W'(1);
          end
        end
        ST_INS_WR: begin
          count_r <= count_r + CNT_W'(1);
          state_r <= ST_DONE;
        end
        ST_Q_RD: begin
          state_r <= ST_Q_CHK;
        end
        ST_Q_CHK: begin
          if (q_hit) begin
            hit_r   <= 1'b1;
            idx_r   <= ENTRY_IDX_W'(lo_idx - IDX_W'(1));
            class_r <= {1'b1, ratio_r};
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (take) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // status and result
  assign stat.busy = (state_r != ST_IDLE);
  assign stat.done = (state_r == ST_DONE);

  assign res.status       = status_r;
  assign res.hit          = hit_r;
  assign res.entry_index  = idx_r;
  assign res.source_class = class_r;
  assign res.entry_count  = ENTRY_CNT_W'(count_r);

endmodule
